// File: src/lfo_modulated_delay_mixer_macros.svh
// Assertion macros shared by the LFO modulated delay mixer.
`ifndef LFO_MODULATED_DELAY_MIXER_MACROS_SVH
`define LFO_MODULATED_DELAY_MIXER_MACROS_SVH

`ifndef SYNTHESIS
// Checked only while reset is released.
`define LMDM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define LMDM_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LMDM_ASSERT(name, prop, msg)
`define LMDM_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// File: src/lmdm_pkg.sv
// Types, constants and fixed-point helpers of the LFO modulated delay mixer.
package lmdm_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int TDATA_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [16:0] WET_FULL = 17'd65536;

  // Odd polynomial coefficients of the sine, Q30.
  localparam logic signed [63:0] CO1 = 64'sd1686629713;
  localparam logic signed [63:0] CO3 = -64'sd693598668;
  localparam logic signed [63:0] CO5 = 64'sd85569306;
  localparam logic signed [63:0] CO7 = -64'sd5026995;
  localparam logic signed [63:0] CO9 = 64'sd172272;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP     = 3'd0,
    REG_PHASE_START    = 3'd1,
    REG_AMPLITUDE      = 3'd2,
    REG_CHANNEL_OFFSET = 3'd3,
    REG_WETNESS        = 3'd4,
    REG_DELAY_FRAMES   = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_MOD,
    ST_DONE
  } lmdm_state_t;

  // Stage strobes from the sequencer to each channel lane.
  typedef struct packed {
    logic look;
    logic mod;
  } lane_ctl_t;

  // Sign-magnitude product with truncation, Q30.
  function automatic logic signed [63:0] mul_q30(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic       neg;
    logic [63:0] ua;
    logic [63:0] ub;
    logic [63:0] m;
    neg = a[63] ^ b[63];
    ua  = a[63] ? 64'(-a) : 64'(a);
    ub  = b[63] ? 64'(-b) : 64'(b);
    m   = (ua * ub) >> 30;
    return neg ? -$signed(m) : $signed(m);
  endfunction

  // One quarter-wave table entry from its Q30 angle fraction, clamped to 0..32767.
  function automatic logic [14:0] sine_entry(input logic [63:0] t_u);
    logic signed [63:0] t;
    logic signed [63:0] t2;
    logic signed [63:0] p;
    logic signed [63:0] v;
    logic [63:0]        mag;
    t   = $signed(t_u);
    t2  = mul_q30(t, t);
    p   = CO9;
    p   = CO7 + mul_q30(p, t2);
    p   = CO5 + mul_q30(p, t2);
    p   = CO3 + mul_q30(p, t2);
    p   = CO1 + mul_q30(p, t2);
    v   = mul_q30(p, t);
    if (v[63]) begin
      return 15'd0;
    end
    mag = (64'(v) + 64'd16384) >> 15;
    return (mag > 64'd32767) ? 15'h7fff : mag[14:0];
  endfunction

  // Shift right with rounding half away from zero, then saturate to 16 bits.
  function automatic logic signed [15:0] round_sat16(input logic signed [63:0] v,
                                                     input int unsigned sh);
    logic [63:0] mag;
    mag = v[63] ? 64'(-v) : 64'(v);
    mag = (mag + (64'd1 << (sh - 1))) >> sh;
    if (v[63]) begin
      return (mag > 64'd32768) ? 16'sh8000 : $signed(16'(64'd0 - mag));
    end
    return (mag > 64'd32767) ? 16'sh7fff : $signed(mag[15:0]);
  endfunction

endpackage

// File: src/lfo_modulated_delay_mixer.sv
// Top level of the stereo LFO modulated delay mixer (chorus).
//
// Usage: stereo frames enter on the in_ stream (in_tdata = left_in in bits
// 15:0, right_in in bits 31:16) and one mixed frame leaves on the out_
// stream per frame taken, in the same order. Registers are written over the
// cfg_ channel (index plus data); cfg_ready is always high, and writes are
// meant to happen only while no frame is in flight.
// A frame runs through the four-step sequencer (accept and delay-ring read,
// sine lookup with the first products, second products, write-back and
// hand-off), and its result is loaded into the output register at hand-off;
// a new frame is taken only once the last one is handed off. Both channels run in parallel
// lanes. The delay ring is one synchronous memory of DEPTH entries holding
// both channels.
// Reset: registers take their defaults, the LFO phase and the write pointer
// go to zero. The ring is not swept; a fill count marks slots never written,
// and those read as silence, so frames are taken right after reset.
// Stall: a finished frame waits in the output register; a new request is
// taken while it waits, and the frame after that holds at its last step
// until the output register frees up.
`include "lfo_modulated_delay_mixer_macros.svh"

module lfo_modulated_delay_mixer #(
  parameter int DEPTH        = 4096,
  parameter int CHANNELS     = 2,
  parameter int SINE_ENTRIES = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input frames.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [lmdm_pkg::TDATA_W-1:0]        in_tdata,   // left_in[15:0], right_in[31:16]
  // Mixed frames.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [lmdm_pkg::TDATA_W-1:0]        out_tdata,  // left_out[15:0], right_out[31:16]
  // Register writes.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lmdm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lmdm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import lmdm_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int XW = AW + 1;
  localparam int RW = CHANNELS * SAMPLE_W;

  // Configuration registers.
  logic [31:0] step_r;
  logic [15:0] amp_r;
  logic [31:0] offset_r;
  logic [16:0] wet_r;
  logic [12:0] delay_r;

  // Control state.
  lmdm_state_t state_r, state_nxt;
  logic [31:0] phase_r;
  logic [AW-1:0] wp_r;
  logic [XW-1:0] fill_r;
  logic          out_tvalid_r;

  // Payload.
  logic signed [15:0] x_r [CHANNELS];
  logic               hit_r;
  logic [RW-1:0]      rdata_r;
  logic [TDATA_W-1:0] out_tdata_r;
  logic [RW-1:0]      ring [DEPTH];

  logic          accept;
  logic          cfg_we;
  logic          ld_out;
  lane_ctl_t     ctl;
  logic [XW-1:0] d_eff;
  logic [XW-1:0] wp_x;
  logic [XW-1:0] rd_x;
  logic [AW-1:0] rd_addr;
  logic          rd_hit;
  logic [16:0]   wet_eff;
  logic [16:0]   dry;
  logic [RW-1:0] wdata;
  logic signed [15:0] lane_mod [CHANNELS];
  logic signed [15:0] lane_mix [CHANNELS];
  logic signed [15:0] mix_right;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid;
  assign accept    = in_tvalid && in_tready;

  // Sequencer: one step per cycle, waiting at the idle step for a frame and
  // holding at the last step while the output register is still occupied.
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    ctl       = '0;
    ld_out    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        ctl.look  = 1'b1;
        state_nxt = ST_MOD;
      end
      ST_MOD: begin
        ctl.mod   = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          ld_out    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Delay clamp, read slot and whether that slot was ever written.
  always_comb begin
    if (delay_r == '0) begin
      d_eff = XW'(1);
    end else if (32'(delay_r) > DEPTH) begin
      d_eff = XW'(DEPTH);
    end else begin
      d_eff = XW'(delay_r);
    end
    wp_x = XW'(wp_r);
    if (wp_x >= d_eff) begin
      rd_x = wp_x - d_eff;
    end else begin
      rd_x = wp_x + XW'(DEPTH) - d_eff;
    end
    rd_addr = rd_x[AW-1:0];
    rd_hit  = (d_eff <= fill_r);
  end

  assign wet_eff = (wet_r > WET_FULL) ? WET_FULL : wet_r;
  assign dry     = WET_FULL - wet_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r       <= 32'd97391;
      amp_r        <= 16'd4096;
      offset_r     <= 32'd0;
      wet_r        <= 17'd32768;
      delay_r      <= 13'd4096;
      phase_r      <= '0;
      wp_r         <= '0;
      fill_r       <= '0;
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PHASE_STEP:     step_r   <= cfg_data;
          REG_AMPLITUDE:      amp_r    <= cfg_data[15:0];
          REG_CHANNEL_OFFSET: offset_r <= cfg_data;
          REG_WETNESS:        wet_r    <= cfg_data[16:0];
          REG_DELAY_FRAMES:   delay_r  <= cfg_data[12:0];
          default: ;
        endcase
      end
      // The phase advances before use, so lanes see the new phase.
      if (cfg_we && cfg_index == REG_PHASE_START) begin
        phase_r <= cfg_data;
      end else if (accept) begin
        phase_r <= phase_r + step_r;
      end
      if (ld_out) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
        if (fill_r != XW'(DEPTH)) begin
          fill_r <= fill_r + 1'b1;
        end
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Delay ring: read at accept, written back when the frame is handed off.
  always_ff @(posedge clk) begin
    if (accept) begin
      rdata_r <= ring[rd_addr];
    end
    if (ld_out) begin
      ring[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hit_r <= rd_hit;
      for (int c = 0; c < CHANNELS; c++) begin
        x_r[c] <= $signed(in_tdata[c*SAMPLE_W +: SAMPLE_W]);
      end
    end
    if (ld_out) begin
      out_tdata_r <= {mix_right, lane_mix[0]};
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    lmdm_lane #(
      .SINE_ENTRIES(SINE_ENTRIES)
    ) u_lane (
      .clk     (clk),
      .ctl     (ctl),
      .x       (x_r[c]),
      .phase   ((c == 0) ? phase_r : phase_r - offset_r),
      .amp     (amp_r),
      .wet     (wet_eff),
      .dry     (dry),
      .delayed (hit_r ? $signed(rdata_r[c*SAMPLE_W +: SAMPLE_W]) : 16'sd0),
      .mod_q   (lane_mod[c]),
      .mix_q   (lane_mix[c])
    );
    assign wdata[c*SAMPLE_W +: SAMPLE_W] = lane_mod[c];
  end

  // With a single channel the right output stays silent.
  assign mix_right = (CHANNELS > 1) ? lane_mix[CHANNELS-1] : 16'sd0;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // An accepted request always starts the lookup step next.
  `LMDM_ASSERT(a_accept_starts, accept |=> state_r == ST_LOOK, "accept did not start lookup")
  // A held result is never overwritten: the sequencer waits at its last step.
  `LMDM_ASSERT(a_no_overwrite,
    (state_r == ST_DONE && out_tvalid_r && !out_tready) |=> state_r == ST_DONE,
    "result slot overwritten")
  // Every ring write moves the write pointer on.
  `LMDM_ASSERT(a_wp_moves, ld_out |=> wp_r != $past(wp_r), "write pointer stuck")
  // The fill count never runs past the ring size; before the first reset it is unknown.
  `LMDM_ASSERT_ALWAYS(a_fill_bound, !rst_n || (fill_r <= XW'(DEPTH)),
    "fill count beyond ring size")

endmodule

// File: src/lmdm_lane.sv
// One channel lane: sine lookup, LFO modulation and wet/dry mix.
module lmdm_lane #(
  parameter int SINE_ENTRIES = 1024
) (
  input  logic                    clk,
  input  lmdm_pkg::lane_ctl_t     ctl,
  input  logic signed [15:0]      x,
  input  logic [31:0]             phase,
  input  logic [15:0]             amp,
  input  logic [16:0]             wet,
  input  logic [16:0]             dry,
  input  logic signed [15:0]      delayed,
  output logic signed [15:0]      mod_q,
  output logic signed [15:0]      mix_q
);
  import lmdm_pkg::*;

  localparam int QUARTER = SINE_ENTRIES / 4;
  localparam int QIW     = $clog2(QUARTER + 1);
  localparam int JW      = 30 + QIW;

  logic [14:0] qtab [QUARTER+1];

  for (genvar k = 0; k <= QUARTER; k++) begin : g_tab
    localparam logic [63:0] TK = (64'(k) << 30) / QUARTER;
    assign qtab[k] = sine_entry(TK);
  end

  logic [JW-1:0]      jprod;
  logic [QIW-1:0]     j;
  logic [QIW-1:0]     idx;
  logic [14:0]        tab_r;
  logic               neg_r;
  logic signed [32:0] m1_r;
  logic signed [33:0] m3_r;
  logic signed [16:0] sine;
  logic signed [49:0] m2_r;
  logic signed [33:0] m4_r;
  logic signed [34:0] mix_sum;

  // Index within the quadrant; odd quadrants run the table backwards.
  assign jprod = JW'(phase[29:0]) * JW'(QUARTER);
  assign j     = jprod[JW-1:30];
  assign idx   = phase[30] ? (QIW'(QUARTER) - j) : j;

  assign sine = neg_r ? -$signed({2'b00, tab_r}) : $signed({2'b00, tab_r});

  always_ff @(posedge clk) begin
    if (ctl.look) begin
      tab_r <= qtab[idx];
      neg_r <= phase[31];
      m1_r  <= x * $signed({1'b0, amp});
      m3_r  <= x * $signed({1'b0, dry});
    end
    if (ctl.mod) begin
      m2_r <= m1_r * sine;
      m4_r <= delayed * $signed({1'b0, wet});
    end
  end

  assign mix_sum = 35'(m3_r) + 35'(m4_r);
  assign mod_q   = round_sat16(64'(m2_r), 27);
  assign mix_q   = round_sat16(64'(mix_sum), 16);

endmodule
